// ===== rtl/net_wrench_regressor_unit_defines.svh =====
// Assertion macros for the net wrench regressor unit.
// Depends on nothing; expects clock and reset in the including scope.
`ifndef NET_WRENCH_REGRESSOR_UNIT_DEFINES_SVH
`define NET_WRENCH_REGRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NWR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nwr assertion failed");

// Next-cycle implication.
`define NWR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nwr assertion failed");

`endif

// ===== rtl/nwr_pkg.sv =====
// Shared types, constants and matrix helpers of the net wrench regressor.
// Depends on nothing.
package nwr_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int VW         = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam int NCOL       = 10;
   localparam int NSLOT      = 4;

   typedef logic [2:0]          row_type;
   typedef logic [1:0]          idx_type;
   typedef logic [3:0]          col_type;
   typedef logic signed [32:0]  opnd_type;
   typedef logic signed [31:0]  val_type;
   typedef logic signed [65:0]  prod_type;

   localparam row_type ROW_FIRST = 3'd0;
   localparam row_type ROW_LAST  = 3'd5;
   localparam row_type ROW_FORCE = 3'd3;

   localparam prod_type MAX_V = (66'sd1 <<< (VW - 1)) - 66'sd1;
   localparam prod_type MIN_V = -MAX_V - 66'sd1;
   localparam prod_type RND_V = (FRAC_BITS > 0) ? (66'sd1 <<< (FRAC_BITS - 1)) : 66'sd0;

   typedef struct packed {
      opnd_type x;
      opnd_type y;
      opnd_type z;
   } vec_type;

   typedef struct packed {
      logic    valid;
      row_type row;
   } ctl_type;

   typedef struct packed {
      val_type vel_ang_x;
      val_type vel_ang_y;
      val_type vel_ang_z;
      val_type vel_lin_x;
      val_type vel_lin_y;
      val_type vel_lin_z;
      val_type acc_ang_x;
      val_type acc_ang_y;
      val_type acc_ang_z;
      val_type acc_lin_x;
      val_type acc_lin_y;
      val_type acc_lin_z;
   } req_type;

   typedef struct packed {
      row_type row_index;
      val_type entry_mass;
      val_type entry_mcx;
      val_type entry_mcy;
      val_type entry_mcz;
      val_type entry_ixx;
      val_type entry_ixy;
      val_type entry_ixz;
      val_type entry_iyy;
      val_type entry_iyz;
      val_type entry_izz;
      logic    last_row;
   } rsp_type;

   // Sign-extend from bit VW-1.
   function automatic opnd_type ext_f(val_type f);
      logic signed [VW-1:0] t;
      t = f[VW-1:0];
      return opnd_type'(t);
   endfunction

   function automatic val_type sat_p(prod_type p);
      if (p > MAX_V) begin
         return val_type'(MAX_V);
      end else if (p < MIN_V) begin
         return val_type'(MIN_V);
      end else begin
         return val_type'(p);
      end
   endfunction

   function automatic opnd_type comp(vec_type v, idx_type i);
      case (i)
         2'd0:    return v.x;
         2'd1:    return v.y;
         default: return v.z;
      endcase
   endfunction

   // Entry of the cross-product matrix S(c).
   function automatic opnd_type skew_el(vec_type c, idx_type r, idx_type col);
      case ({r, col})
         4'b0001: return -c.z;
         4'b0010: return c.y;
         4'b0100: return c.z;
         4'b0110: return -c.x;
         4'b1000: return -c.y;
         4'b1001: return c.x;
         default: return '0;
      endcase
   endfunction

   // Entry of the momentum regressor for twist (r, s).
   function automatic opnd_type mom_el(vec_type r, vec_type s, row_type row, col_type col);
      idx_type lr;
      idx_type cc;
      lr = (row >= ROW_FORCE) ? idx_type'(row - ROW_FORCE) : idx_type'(row);
      cc = idx_type'(col - 4'd1);
      if (row < ROW_FORCE) begin
         if (col >= 4'd1 && col <= 4'd3) begin
            return -skew_el(s, lr, cc);
         end
         case ({lr, col})
            6'h04:   return r.x;
            6'h05:   return r.y;
            6'h06:   return r.z;
            6'h15:   return r.x;
            6'h17:   return r.y;
            6'h18:   return r.z;
            6'h26:   return r.x;
            6'h28:   return r.y;
            6'h29:   return r.z;
            default: return '0;
         endcase
      end else begin
         if (col == 4'd0) begin
            return comp(s, lr);
         end else if (col <= 4'd3) begin
            return skew_el(r, lr, cc);
         end else begin
            return '0;
         end
      end
   endfunction

endpackage

// ===== rtl/nwr_seq.sv =====
// Row sequencer and operand select: holds the item, issues one row a cycle.
// Depends on nwr_pkg.
module nwr_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  nwr_pkg::req_type     req_data,
   output logic                 busy,
   output nwr_pkg::ctl_type     op_ctl,
   output nwr_pkg::opnd_type    op_coef [4],
   output nwr_pkg::opnd_type    op_mv   [4][10],
   output nwr_pkg::val_type     op_ma   [10]
);
   import nwr_pkg::*;

   req_type  item_ff;
   row_type  cnt_ff, cnt_in;
   logic     act_ff, act_in;
   logic     take;
   ctl_type  ctl_ff, ctl_in;
   opnd_type coef_ff [NSLOT];
   opnd_type coef_in [NSLOT];
   opnd_type mv_ff   [NSLOT][NCOL];
   opnd_type mv_in   [NSLOT][NCOL];
   val_type  ma_ff   [NCOL];
   val_type  ma_in   [NCOL];
   vec_type  w, u, wa, ua;
   idx_type  lr, ka, kb;
   row_type  ks [NSLOT];

   assign busy = act_ff && (cnt_ff != ROW_LAST);
   assign take = start && !busy;

   always_comb begin
      act_in = act_ff;
      cnt_in = cnt_ff;
      if (take) begin
         act_in = 1'b1;
         cnt_in = ROW_FIRST;
      end else if (act_ff) begin
         if (cnt_ff == ROW_LAST) begin
            act_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_comb begin
      w  = '{x: ext_f(item_ff.vel_ang_x), y: ext_f(item_ff.vel_ang_y),
             z: ext_f(item_ff.vel_ang_z)};
      u  = '{x: ext_f(item_ff.vel_lin_x), y: ext_f(item_ff.vel_lin_y),
             z: ext_f(item_ff.vel_lin_z)};
      wa = '{x: ext_f(item_ff.acc_ang_x), y: ext_f(item_ff.acc_ang_y),
             z: ext_f(item_ff.acc_ang_z)};
      ua = '{x: ext_f(item_ff.acc_lin_x), y: ext_f(item_ff.acc_lin_y),
             z: ext_f(item_ff.acc_lin_z)};
      lr = (cnt_ff >= ROW_FORCE) ? idx_type'(cnt_ff - ROW_FORCE) : idx_type'(cnt_ff);
      case (lr)
         2'd0: begin
            ka = 2'd1;
            kb = 2'd2;
         end
         2'd1: begin
            ka = 2'd0;
            kb = 2'd2;
         end
         default: begin
            ka = 2'd0;
            kb = 2'd1;
         end
      endcase
      // The X row has two nonzero terms in each skew block; keep them in k order.
      coef_in[0] = skew_el(w, lr, ka);
      coef_in[1] = skew_el(w, lr, kb);
      if (cnt_ff < ROW_FORCE) begin
         coef_in[2] = skew_el(u, lr, ka);
         coef_in[3] = skew_el(u, lr, kb);
         ks[0] = row_type'(ka);
         ks[1] = row_type'(kb);
         ks[2] = row_type'(ka) + ROW_FORCE;
         ks[3] = row_type'(kb) + ROW_FORCE;
      end else begin
         coef_in[2] = '0;
         coef_in[3] = '0;
         ks[0] = row_type'(ka) + ROW_FORCE;
         ks[1] = row_type'(kb) + ROW_FORCE;
         ks[2] = ROW_FIRST;
         ks[3] = ROW_FIRST;
      end
      for (int s = 0; s < NSLOT; s++) begin
         for (int j = 0; j < NCOL; j++) begin
            mv_in[s][j] = mom_el(w, u, ks[s], col_type'(j));
         end
      end
      for (int j = 0; j < NCOL; j++) begin
         ma_in[j] = sat_p(prod_type'(mom_el(wa, ua, cnt_ff, col_type'(j))));
      end
      ctl_in.valid = act_ff;
      ctl_in.row   = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         cnt_ff <= ROW_FIRST;
         ctl_ff <= '0;
      end else begin
         act_ff <= act_in;
         cnt_ff <= cnt_in;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
      coef_ff <= coef_in;
      mv_ff   <= mv_in;
      ma_ff   <= ma_in;
   end

   assign op_ctl  = ctl_ff;
   assign op_coef = coef_ff;
   assign op_mv   = mv_ff;
   assign op_ma   = ma_ff;

endmodule

// ===== rtl/nwr_mul.sv =====
// Product stages: forty exact products, then round and saturate.
// Depends on nwr_pkg.
module nwr_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  nwr_pkg::ctl_type     op_ctl,
   input  nwr_pkg::opnd_type    op_coef [4],
   input  nwr_pkg::opnd_type    op_mv   [4][10],
   input  nwr_pkg::val_type     op_ma   [10],
   output nwr_pkg::ctl_type     tm_ctl,
   output nwr_pkg::val_type     tm_term [4][10],
   output nwr_pkg::val_type     tm_ma   [10]
);
   import nwr_pkg::*;

   ctl_type  c1_ff, c2_ff;
   prod_type p_ff  [NSLOT][NCOL];
   prod_type p_in  [NSLOT][NCOL];
   val_type  t_ff  [NSLOT][NCOL];
   val_type  t_in  [NSLOT][NCOL];
   val_type  m1_ff [NCOL];
   val_type  m2_ff [NCOL];

   always_comb begin
      for (int s = 0; s < NSLOT; s++) begin
         for (int j = 0; j < NCOL; j++) begin
            p_in[s][j] = prod_type'(op_coef[s]) * prod_type'(op_mv[s][j]);
            // Round half up, then floor shift.
            t_in[s][j] = sat_p((p_ff[s][j] + RND_V) >>> FRAC_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
      end else begin
         c1_ff <= op_ctl;
         c2_ff <= c1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      t_ff  <= t_in;
      m1_ff <= op_ma;
      m2_ff <= m1_ff;
   end

   assign tm_ctl  = c2_ff;
   assign tm_term = t_ff;
   assign tm_ma   = m2_ff;

endmodule

// ===== rtl/nwr_acc.sv =====
// Saturating accumulation in two stages, two terms each, into the result row.
// Depends on nwr_pkg.
module nwr_acc (
   input  logic                 clock,
   input  logic                 reset,
   input  nwr_pkg::ctl_type     tm_ctl,
   input  nwr_pkg::val_type     tm_term [4][10],
   input  nwr_pkg::val_type     tm_ma   [10],
   output logic                 rsp_valid,
   output nwr_pkg::rsp_type     rsp_data
);
   import nwr_pkg::*;

   ctl_type c1_ff, c2_ff;
   val_type a1_ff [NCOL];
   val_type a1_in [NCOL];
   val_type a2_ff [NCOL];
   val_type a2_in [NCOL];
   val_type t23_ff [2][NCOL];
   val_type h1    [NCOL];
   val_type h2    [NCOL];

   always_comb begin
      for (int j = 0; j < NCOL; j++) begin
         h1[j]    = sat_p(prod_type'(tm_ma[j]) + prod_type'(tm_term[0][j]));
         a1_in[j] = sat_p(prod_type'(h1[j]) + prod_type'(tm_term[1][j]));
         h2[j]    = sat_p(prod_type'(a1_ff[j]) + prod_type'(t23_ff[0][j]));
         a2_in[j] = sat_p(prod_type'(h2[j]) + prod_type'(t23_ff[1][j]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
      end else begin
         c1_ff <= tm_ctl;
         c2_ff <= c1_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff <= a1_in;
      a2_ff <= a2_in;
      for (int j = 0; j < NCOL; j++) begin
         t23_ff[0][j] <= tm_term[2][j];
         t23_ff[1][j] <= tm_term[3][j];
      end
   end

   always_comb begin
      rsp_valid           = c2_ff.valid;
      rsp_data.row_index  = c2_ff.row;
      rsp_data.entry_mass = a2_ff[0];
      rsp_data.entry_mcx  = a2_ff[1];
      rsp_data.entry_mcy  = a2_ff[2];
      rsp_data.entry_mcz  = a2_ff[3];
      rsp_data.entry_ixx  = a2_ff[4];
      rsp_data.entry_ixy  = a2_ff[5];
      rsp_data.entry_ixz  = a2_ff[6];
      rsp_data.entry_iyy  = a2_ff[7];
      rsp_data.entry_iyz  = a2_ff[8];
      rsp_data.entry_izz  = a2_ff[9];
      rsp_data.last_row   = (c2_ff.row == ROW_LAST);
   end

endmodule

// ===== rtl/net_wrench_regressor_unit.sv =====
// Net wrench regressor unit: one twist pair in, six regressor rows out.
// Depends on nwr_pkg, nwr_seq, nwr_mul, nwr_acc and the defines header.
//
// Raise start with a velocity and acceleration twist on req_data; the item is
// taken on any edge where busy is low. The unit then emits the 6x10 regressor
// M(a) + X(v)*M(v) as six rows, one row per cycle, in row order 0..5, each on
// rsp_data for exactly one cycle with rsp_valid high; last_row marks row 5.
// The receiver cannot stall, so capture rows as they appear. A new item is
// taken in the same cycle the previous one issues its last row, so rows of
// consecutive items follow without a gap on the output. Between the row
// counter and the result ports sit operand select, multiply, round/saturate,
// and two saturating accumulate stages, each of them registered.
// All values are signed Q16.16; products round half up and every sum saturates.
module net_wrench_regressor_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  nwr_pkg::req_type     req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output nwr_pkg::rsp_type     rsp_data
);
   import nwr_pkg::*;
   `include "net_wrench_regressor_unit_defines.svh"

   ctl_type  op_ctl;
   opnd_type op_coef [NSLOT];
   opnd_type op_mv   [NSLOT][NCOL];
   val_type  op_ma   [NCOL];
   ctl_type  tm_ctl;
   val_type  tm_term [NSLOT][NCOL];
   val_type  tm_ma   [NCOL];

   // Hold the item and walk its rows.
   nwr_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .op_ctl   (op_ctl),
      .op_coef  (op_coef),
      .op_mv    (op_mv),
      .op_ma    (op_ma)
   );

   // Form and round the X(v)*M(v) terms.
   nwr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .op_ctl  (op_ctl),
      .op_coef (op_coef),
      .op_mv   (op_mv),
      .op_ma   (op_ma),
      .tm_ctl  (tm_ctl),
      .tm_term (tm_term),
      .tm_ma   (tm_ma)
   );

   // Add terms onto M(a) in k order and drive the row out.
   nwr_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .tm_ctl    (tm_ctl),
      .tm_term   (tm_term),
      .tm_ma     (tm_ma),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `NWR_ASSERT_NXT(a_busy_after_take, start && !busy, busy)
   `NWR_ASSERT_NXT(a_rows_contiguous, rsp_valid && (rsp_data.row_index != ROW_LAST),
                   rsp_valid && (rsp_data.row_index == $past(rsp_data.row_index) + 3'd1))
   `NWR_ASSERT_IMP(a_last_flag, rsp_valid, rsp_data.last_row == (rsp_data.row_index == ROW_LAST))
   `NWR_ASSERT_IMP(a_row_range, rsp_valid, rsp_data.row_index <= ROW_LAST)

endmodule
